FILE: rtl/core/ows_pkg.sv
// Shared constants, types and the CRC step for the scratchpad decoder.
package ows_pkg;

  localparam int FRAME_BYTES = 9;

  // Byte positions inside the scratchpad frame.
  localparam int POS_TEMP_LSB = 0;
  localparam int POS_TEMP_MSB = 1;
  localparam int POS_CONFIG   = 4;
  localparam int POS_REMAIN   = 6;
  localparam int POS_PER_DEG  = 7;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Sensor family codes.
  localparam logic [7:0] FAM_HIGH_A = 8'h28;
  localparam logic [7:0] FAM_HIGH_B = 8'h22;
  localparam logic [7:0] FAM_LOW    = 8'h10;

  // Resolution codes of the high-resolution family.
  localparam logic [7:0] RES_12BIT = 8'h7F;
  localparam logic [7:0] RES_11BIT = 8'h5F;
  localparam logic [7:0] RES_10BIT = 8'h3F;
  localparam logic [7:0] RES_9BIT  = 8'h1F;

  // Configuration register indexes.
  localparam int          CFG_IDX_W  = 8;
  localparam int          CFG_DATA_W = 8;
  localparam logic [7:0]  REG_FAMILY = 8'd0;
  localparam logic [7:0]  REG_ROUND  = 8'd1;
  localparam logic [7:0]  FAMILY_RESET = 8'd40;

  localparam int                 TENTHS_MAX     = 20480;
  localparam logic signed [15:0] ABSENT_TENTHS  = -16'sd1270;
  localparam logic signed [15:0] POWERON_TENTHS = 16'sd850;

  // Divider datapath sizes.
  localparam int NUM_W = 29;
  localparam int MAG_W = 28;
  localparam int DEN_W = 10;
  localparam int CNT_W = 5;

  typedef enum logic [1:0] {
    CONV_HIGH,
    CONV_LOW,
    CONV_KEEP
  } conv_e;

  typedef struct packed {
    conv_e       conv;
    logic [15:0] raw;
    logic [7:0]  remain;
    logic [7:0]  per_deg;
    logic        crc_ok;
    logic        reinit;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_SCALE,
    BK_DIV,
    BK_ROUND,
    BK_OUT
  } back_state_e;

  // One byte through the reflected CRC-8, LSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       mix;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ b[i];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/ows_if.sv
// Channel interfaces: scratchpad bytes in, decoded results out, register writes.
interface ows_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface ows_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic               present;
  logic               changed;
  logic               crc_ok;
  logic               bridge_reinit;
  modport source (output valid, output temperature_tenths, output present, output changed,
                  output crc_ok, output bridge_reinit, input ready);
  modport sink   (input valid, input temperature_tenths, input present, input changed,
                  input crc_ok, input bridge_reinit, output ready);
endinterface

interface ows_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ows_front.sv
// Front end: frame tracking, CRC check, byte capture and conversion classification.
module ows_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ows_byte_if.sink      byte_i,
  input  logic [7:0]    family_code_i,
  output logic          job_valid_o,
  output ows_pkg::job_t job_o,
  input  logic          job_ready_i
);

  logic [3:0] pos_q, pos_d;
  logic [7:0] crc_q, crc_d;
  logic       az_q, az_d;
  logic [7:0] bytes_q [ows_pkg::FRAME_BYTES-1];

  logic       accept;
  logic [3:0] pos_eff;
  logic [7:0] crc_eff;
  logic       az_eff;
  logic       wr_en;
  logic [7:0] b;
  logic [7:0] cfg_b;
  logic [15:0] raw;

  assign byte_i.ready = job_ready_i;
  assign accept       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.data_byte;

  // A frame start restarts the frame at this very beat.
  assign pos_eff = byte_i.frame_start ? 4'd0 : pos_q;
  assign crc_eff = byte_i.frame_start ? 8'd0 : crc_q;
  assign az_eff  = byte_i.frame_start ? 1'b1 : az_q;

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    az_d        = az_q;
    wr_en       = 1'b0;
    job_valid_o = 1'b0;
    if (accept) begin
      pos_d = pos_eff;
      crc_d = crc_eff;
      az_d  = az_eff;
      if (pos_eff < 4'(ows_pkg::FRAME_BYTES - 1)) begin
        wr_en = 1'b1;
        crc_d = ows_pkg::crc8_update(crc_eff, b);
        pos_d = pos_eff + 4'd1;
        az_d  = az_eff && (b == 8'd0);
      end else if (pos_eff == 4'(ows_pkg::FRAME_BYTES - 1)) begin
        job_valid_o = 1'b1;
        pos_d       = 4'(ows_pkg::FRAME_BYTES);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      crc_q <= 8'd0;
      az_q  <= 1'b1;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      az_q  <= az_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bytes_q[pos_eff[2:0]] <= b;
    end
  end

  assign cfg_b = bytes_q[ows_pkg::POS_CONFIG];
  assign raw   = {bytes_q[ows_pkg::POS_TEMP_MSB], bytes_q[ows_pkg::POS_TEMP_LSB]};

  always_comb begin
    job_o.raw     = raw;
    job_o.remain  = bytes_q[ows_pkg::POS_REMAIN];
    job_o.per_deg = bytes_q[ows_pkg::POS_PER_DEG];
    job_o.crc_ok  = (b == crc_eff) && (bytes_q[ows_pkg::POS_TEMP_LSB] != 8'd0) && (b != 8'd0);
    job_o.reinit  = az_eff && (b == 8'd0);
    job_o.conv    = ows_pkg::CONV_KEEP;
    if (family_code_i == ows_pkg::FAM_HIGH_A || family_code_i == ows_pkg::FAM_HIGH_B) begin
      job_o.conv = ows_pkg::CONV_HIGH;
      case (cfg_b)
        ows_pkg::RES_12BIT: job_o.raw = raw;
        ows_pkg::RES_11BIT: job_o.raw = raw & 16'hFFFE;
        ows_pkg::RES_10BIT: job_o.raw = raw & 16'hFFFC;
        ows_pkg::RES_9BIT:  job_o.raw = raw & 16'hFFF8;
        default:            job_o.conv = ows_pkg::CONV_KEEP;
      endcase
    end else if (family_code_i == ows_pkg::FAM_LOW) begin
      job_o.conv = ows_pkg::CONV_LOW;
    end
  end

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 4'(ows_pkg::FRAME_BYTES))
    else $error("frame position ran past the end of the frame");

endmodule

FILE: rtl/core/ows_queue.sv
// Two-entry queue of classified frames between the front and the back end.
module ows_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ows_pkg::job_t push_data_i,
  output logic          full_o,
  output logic          pop_valid_o,
  output ows_pkg::job_t pop_data_o,
  input  logic          pop_ready_i
);

  ows_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q, count_d;
  logic          pop;

  assign full_o      = (count_q == 2'd2);
  assign pop_valid_o = (count_q != 2'd0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign pop         = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("frame pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count out of range");

endmodule

FILE: rtl/core/ows_back.sv
// Back end: conversion to tenths with a shared bit-serial divider, presence and change tracking.
module ows_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  ows_pkg::job_t job_i,
  output logic          job_ready_o,
  input  logic          round_half_i,
  ows_res_if.source     res_o
);

  localparam int NUM_W = ows_pkg::NUM_W;
  localparam int MAG_W = ows_pkg::MAG_W;
  localparam int DEN_W = ows_pkg::DEN_W;
  localparam int CNT_W = ows_pkg::CNT_W;
  localparam int TW    = MAG_W + 7;
  localparam logic signed [TW-1:0] T_MAX = TW'(ows_pkg::TENTHS_MAX);
  localparam logic signed [TW-1:0] T_MIN = -TW'(ows_pkg::TENTHS_MAX);

  ows_pkg::back_state_e state_q, state_d;

  ows_pkg::job_t            job_q;
  logic signed [NUM_W-1:0]  num_q;
  logic signed [11:0]       off_q;
  logic [DEN_W-1:0]         den_q;
  logic                     neg_q;
  logic [MAG_W-1:0]         quo_q;
  logic [DEN_W-1:0]         rem_q;
  logic [CNT_W-1:0]         cnt_q;

  logic signed [15:0]       cur_q;
  logic signed [15:0]       last_q;
  logic signed [15:0]       out_temp_q;
  logic                     out_present_q, out_changed_q, out_crc_q, out_reinit_q;

  // Control decoded from the state.
  logic pop, div_done, do_round;

  // Datapath nets.
  logic signed [15:0]      half;
  logic signed [17:0]      h4m1;
  logic signed [26:0]      prod;
  logic signed [11:0]      off_d;
  logic signed [NUM_W-1:0] scaled;
  logic [DEN_W:0]          trial;
  logic                    ge;
  logic [TW-1:0]           base;
  logic signed [TW-1:0]    t_signed;
  logic signed [TW-1:0]    t_full;
  logic signed [15:0]      t_sat;
  logic [16:0]             r100, den25, den74;
  logic                    pres_new;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ows_pkg::BK_IDLE:  if (job_valid_i) begin
        state_d = job_i.crc_ok ? ows_pkg::BK_MUL : ows_pkg::BK_ROUND;
      end
      ows_pkg::BK_MUL:   state_d = ows_pkg::BK_SUM;
      ows_pkg::BK_SUM:   state_d = ows_pkg::BK_SCALE;
      ows_pkg::BK_SCALE: state_d = ows_pkg::BK_DIV;
      ows_pkg::BK_DIV:   if (div_done) begin
        state_d = ows_pkg::BK_ROUND;
      end
      ows_pkg::BK_ROUND: state_d = ows_pkg::BK_OUT;
      ows_pkg::BK_OUT:   if (res_o.ready) begin
        state_d = ows_pkg::BK_IDLE;
      end
      default:           state_d = ows_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    job_ready_o = 1'b0;
    res_o.valid = 1'b0;
    do_round    = 1'b0;
    case (state_q)
      ows_pkg::BK_IDLE:  job_ready_o = 1'b1;
      ows_pkg::BK_ROUND: do_round    = 1'b1;
      ows_pkg::BK_OUT:   res_o.valid = 1'b1;
      default:           job_ready_o = 1'b0;
    endcase
  end

  assign pop      = job_ready_o && job_valid_i;
  assign div_done = (cnt_q == CNT_W'(MAG_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ows_pkg::BK_IDLE;
      cur_q         <= ows_pkg::ABSENT_TENTHS;
      last_q        <= ows_pkg::ABSENT_TENTHS;
      out_present_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_round) begin
        if (job_q.crc_ok) begin
          cur_q         <= t_sat;
          out_present_q <= pres_new;
          if (pres_new && (last_q != t_sat)) begin
            last_q <= t_sat;
          end
        end else begin
          out_present_q <= 1'b0;
        end
      end
    end
  end

  // Low-resolution family: floor(raw/2) - 1/4 + (per_deg - remain) / per_deg.
  assign half  = $signed(job_q.raw) >>> 1;
  assign h4m1  = ($signed(18'(half)) <<< 2) - 18'sd1;
  assign prod  = h4m1 * $signed({1'b0, job_q.per_deg});
  assign off_d = ($signed({4'b0, job_q.per_deg}) - $signed({4'b0, job_q.remain})) <<< 2;

  // Truncation scales by ten before the division; half rounding divides the value itself.
  assign scaled = round_half_i ? num_q : (num_q <<< 3) + (num_q <<< 1);

  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    case (state_q)
      ows_pkg::BK_IDLE: begin
        if (pop) begin
          job_q <= job_i;
        end
      end
      ows_pkg::BK_MUL: begin
        case (job_q.conv)
          ows_pkg::CONV_HIGH: begin
            num_q <= NUM_W'($signed(job_q.raw));
            den_q <= DEN_W'(16);
            off_q <= 12'sd0;
          end
          ows_pkg::CONV_LOW: begin
            if (job_q.per_deg == 8'd0) begin
              num_q <= NUM_W'(h4m1);
              den_q <= DEN_W'(4);
              off_q <= 12'sd0;
            end else begin
              num_q <= NUM_W'(prod);
              den_q <= {job_q.per_deg, 2'b00};
              off_q <= off_d;
            end
          end
          default: begin
            num_q <= NUM_W'(cur_q);
            den_q <= DEN_W'(10);
            off_q <= 12'sd0;
          end
        endcase
      end
      ows_pkg::BK_SUM: num_q <= num_q + NUM_W'(off_q);
      ows_pkg::BK_SCALE: begin
        neg_q <= scaled[NUM_W-1];
        quo_q <= scaled[NUM_W-1] ? MAG_W'(-scaled) : MAG_W'(scaled);
        rem_q <= '0;
        cnt_q <= '0;
      end
      ows_pkg::BK_DIV: begin
        quo_q <= {quo_q[MAG_W-2:0], ge};
        rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ows_pkg::BK_ROUND: begin
        out_temp_q    <= job_q.crc_ok ? t_sat : cur_q;
        out_changed_q <= job_q.crc_ok && pres_new && (last_q != t_sat);
        out_crc_q     <= job_q.crc_ok;
        out_reinit_q  <= job_q.reinit;
      end
      default: num_q <= num_q;
    endcase
  end

  // Quotient and remainder come as magnitudes; the sign is put back here.
  assign r100  = 17'(rem_q) * 17'd100;
  assign den25 = 17'(den_q) * 17'd25;
  assign den74 = 17'(den_q) * 17'd74;

  always_comb begin
    base     = round_half_i ? (TW'(quo_q) << 3) + (TW'(quo_q) << 1) : TW'(quo_q);
    t_signed = neg_q ? -$signed(base) : $signed(base);
    t_full   = t_signed;
    // A negative value has a remainder of zero or below and takes no adjustment.
    if (round_half_i && !neg_q) begin
      if (r100 >= den25 && r100 <= den74) begin
        t_full = t_signed + TW'(5);
      end else if ({rem_q, 1'b0} > {1'b0, den_q}) begin
        t_full = t_signed + TW'(10);
      end
    end
    if (t_full > T_MAX) begin
      t_sat = 16'(T_MAX);
    end else if (t_full < T_MIN) begin
      t_sat = 16'(T_MIN);
    end else begin
      t_sat = t_full[15:0];
    end
  end

  assign pres_new = (t_sat != ows_pkg::ABSENT_TENTHS) && (t_sat != ows_pkg::POWERON_TENTHS);

  assign res_o.temperature_tenths = out_temp_q;
  assign res_o.present            = out_present_q;
  assign res_o.changed            = out_changed_q;
  assign res_o.crc_ok             = out_crc_q;
  assign res_o.bridge_reinit      = out_reinit_q;

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= 16'sd20480 && cur_q >= -16'sd20480)
    else $error("current temperature outside the saturation range");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ows_pkg::BK_ROUND && job_q.crc_ok) |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_changed_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ows_pkg::BK_OUT && out_changed_q) |-> (out_present_q && out_crc_q))
    else $error("change flagged on a reading that is not present");

endmodule

FILE: rtl/core/onewire_temp_scratchpad_decoder.sv
// Top level of the one-wire temperature scratchpad decoder.
//
// Usage:
//   byte_i carries the scratchpad one byte per beat; frame_start marks byte 0.
//   A frame of nine bytes is checked with CRC-8 (reflected 0x8C) over bytes
//   0..7 against byte 8. After the ninth byte one result beat appears on res_o
//   with the temperature in tenths of a degree and the status flags.
//   cfg_i writes the family code (index 0) and the rounding mode (index 1);
//   it is always ready and should be written only while no frame is pending.
// Timing:
//   Bytes are taken at one per cycle while the queue is not full. A good
//   frame passes the back end through multiply, sum, scale, the bit-serial
//   divider and rounding before res_o.valid rises; a bad CRC skips to rounding.
//   The back end takes no new frame until its result beat has been taken.
// Reset and stalls:
//   Reset restarts frame tracking, sets the temperature to -127.0 degrees and
//   clears presence. When res_o stalls, the result holds, up to two finished
//   frames wait in the queue, and byte_i.ready drops only when that is full.
module onewire_temp_scratchpad_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  ows_byte_if.sink  byte_i,
  ows_res_if.source res_o,
  ows_cfg_if.sink   cfg_i
);

  logic [7:0]    family_q;
  logic          round_q;
  logic          job_push;
  ows_pkg::job_t job_in;
  logic          queue_full;
  logic          job_valid;
  ows_pkg::job_t job_out;
  logic          job_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q <= ows_pkg::FAMILY_RESET;
      round_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ows_pkg::REG_FAMILY: family_q <= cfg_i.data;
        ows_pkg::REG_ROUND:  round_q  <= cfg_i.data[0];
        default:             round_q  <= round_q;
      endcase
    end
  end

  ows_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_i        (byte_i),
    .family_code_i (family_q),
    .job_valid_o   (job_push),
    .job_o         (job_in),
    .job_ready_i   (!queue_full)
  );

  ows_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (queue_full),
    .pop_valid_o (job_valid),
    .pop_data_o  (job_out),
    .pop_ready_i (job_ready)
  );

  ows_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job_out),
    .job_ready_o  (job_ready),
    .round_half_i (round_q),
    .res_o        (res_o)
  );

endmodule

FILE: verif/scratchpad_tb_pkg.sv
`timescale 1ns / 1ps
// Shared testbench types and the scratchpad CRC used by the stimulus and the checker.
package scratchpad_tb_pkg;

  typedef logic [7:0] frame_t [ows_pkg::FRAME_BYTES];

  typedef struct packed {
    logic signed [15:0] tenths;
    logic               present;
    logic               changed;
    logic               crc_ok;
    logic               reinit;
  } reading_t;

  // Reflected CRC-8, one byte shifted in LSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ b[i]) ? ((c >> 1) ^ ows_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_crc(input frame_t f);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < ows_pkg::FRAME_BYTES - 1; i++) begin
      c = crc8_step(c, f[i]);
    end
    return c;
  endfunction

endpackage

FILE: verif/scratchpad_result_checker.sv
`timescale 1ns / 1ps
// Watches the decoder channels, predicts each frame's reading and compares the result beats.
module scratchpad_result_checker
  import ows_pkg::*;
  import scratchpad_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic               byte_ready_i,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic signed [15:0] temperature_tenths_i,
  input  logic               present_i,
  input  logic               changed_i,
  input  logic               crc_ok_i,
  input  logic               bridge_reinit_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [7:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int                 pending_o,
  output int                 mismatches_o,
  output int                 results_o,
  output int                 good_crc_o
);

  logic [7:0]         family;
  logic               round_sel;
  int                 byte_pos;
  logic [7:0]         crc_acc;
  frame_t             frame_buf;
  logic               all_zero;
  logic signed [15:0] cur_tenths;
  logic signed [15:0] last_tenths;
  reading_t           expected_readings[$];
  int                 mismatch_count;
  int                 result_count;
  int                 good_crc_count;

  function automatic logic signed [15:0] round_to_tenths(input longint num, input longint den);
    longint ip;
    longint rem;
    longint t;
    if (round_sel) begin
      ip  = num / den;
      rem = num - ip * den;
      if (rem * 100 >= 25 * den && rem * 100 <= 74 * den) begin
        t = ip * 10 + 5;
      end else begin
        t = ip * 10 + ((2 * rem > den) ? 10 : 0);
      end
    end else begin
      t = (num * 10) / den;
    end
    if (t > TENTHS_MAX) t = TENTHS_MAX;
    if (t < -TENTHS_MAX) t = -TENTHS_MAX;
    return t[15:0];
  endfunction

  // Converts the buffered frame; an unknown family or resolution re-rounds the old value.
  function automatic logic signed [15:0] decode_frame();
    logic [15:0] raw;
    longint      num;
    longint      den;
    longint      half;
    longint      cr;
    longint      cpc;
    raw = {frame_buf[POS_TEMP_MSB], frame_buf[POS_TEMP_LSB]};
    num = cur_tenths;
    den = 10;
    if (family == FAM_HIGH_A || family == FAM_HIGH_B) begin
      case (frame_buf[POS_CONFIG])
        RES_12BIT: begin num = longint'($signed(raw)); den = 16; end
        RES_11BIT: begin num = longint'($signed(raw & 16'hFFFE)); den = 16; end
        RES_10BIT: begin num = longint'($signed(raw & 16'hFFFC)); den = 16; end
        RES_9BIT:  begin num = longint'($signed(raw & 16'hFFF8)); den = 16; end
        default: ;
      endcase
    end else if (family == FAM_LOW) begin
      half = longint'($signed(raw)) >>> 1;
      cr   = longint'(frame_buf[POS_REMAIN]);
      cpc  = longint'(frame_buf[POS_PER_DEG]);
      if (cpc == 0) begin
        num = half * 4 - 1;
        den = 4;
      end else begin
        num = (half * 4 - 1) * cpc + 4 * (cpc - cr);
        den = 4 * cpc;
      end
    end
    return round_to_tenths(num, den);
  endfunction

  task automatic close_frame(input logic [7:0] crc_byte);
    reading_t r;
    r = '0;
    r.reinit = all_zero;
    r.crc_ok = (crc_byte == crc_acc) && (frame_buf[POS_TEMP_LSB] != 8'h00) &&
               (crc_byte != 8'h00);
    if (r.crc_ok) begin
      cur_tenths = decode_frame();
      r.present  = (cur_tenths != ABSENT_TENTHS) && (cur_tenths != POWERON_TENTHS);
      if (r.present && last_tenths != cur_tenths) begin
        r.changed   = 1'b1;
        last_tenths = cur_tenths;
      end
    end
    r.tenths = cur_tenths;
    expected_readings.push_back(r);
  endtask

  task automatic flag(input string what, input reading_t e, input reading_t g);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected tenths %0d present %b changed %b crc_ok %b reinit %b",
               $time, what, e.tenths, e.present, e.changed, e.crc_ok, e.reinit);
      $display("%0t: %s: got      tenths %0d present %b changed %b crc_ok %b reinit %b",
               $time, what, g.tenths, g.present, g.changed, g.crc_ok, g.reinit);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      family         = FAMILY_RESET;
      round_sel      = 1'b0;
      byte_pos       = 0;
      crc_acc        = 8'h00;
      all_zero       = 1'b1;
      cur_tenths     = ABSENT_TENTHS;
      last_tenths    = ABSENT_TENTHS;
      mismatch_count = 0;
      result_count   = 0;
      good_crc_count = 0;
      expected_readings.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_FAMILY) begin
          family = cfg_data_i;
        end else if (cfg_index_i == REG_ROUND) begin
          round_sel = cfg_data_i[0];
        end
      end
      if (byte_valid_i && byte_ready_i) begin
        if (frame_start_i) begin
          byte_pos = 0;
          crc_acc  = 8'h00;
          all_zero = 1'b1;
        end
        // Bytes past the ninth without a new start marker are dropped.
        if (byte_pos < FRAME_BYTES) begin
          frame_buf[byte_pos] = data_byte_i;
          if (data_byte_i != 8'h00) all_zero = 1'b0;
          if (byte_pos < FRAME_BYTES - 1) begin
            crc_acc = crc8_step(crc_acc, data_byte_i);
            byte_pos++;
          end else begin
            byte_pos = FRAME_BYTES;
            close_frame(data_byte_i);
          end
        end
      end
      if (res_valid_i && res_ready_i) begin
        got = {temperature_tenths_i, present_i, changed_i, crc_ok_i, bridge_reinit_i};
        if (expected_readings.size() == 0) begin
          flag("result beat with nothing expected", '0, got);
        end else begin
          want = expected_readings.pop_front();
          result_count++;
          if (want.crc_ok) good_crc_count++;
          if (got !== want) flag("result mismatch", want, got);
        end
      end
    end
    pending_o    <= expected_readings.size();
    mismatches_o <= mismatch_count;
    results_o    <= result_count;
    good_crc_o   <= good_crc_count;
  end

endmodule

FILE: verif/onewire_temp_scratchpad_decoder_test.sv
`timescale 1ns / 1ps
// Testbench top: drives scratchpad frames and register writes into the decoder and gives the verdict.
module onewire_temp_scratchpad_decoder_test;
  import ows_pkg::*;
  import scratchpad_tb_pkg::*;

  localparam int RANDOM_BYTES  = 1050;
  localparam int SETTING_SPAN  = 110;
  localparam int SETTLE_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int          gap_pct;
  int          stall_pct;
  int          bytes_sent = 0;
  int          settings_used = 0;
  int          pending;
  int          mismatches;
  int          results;
  int          good_crc;
  logic [15:0] last_raw = 16'h0191;
  frame_t      zero_frame = '{default: 8'h00};

  ows_byte_if byte_ch ();
  ows_res_if  res_ch ();
  ows_cfg_if  cfg_ch ();

  onewire_temp_scratchpad_decoder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  scratchpad_result_checker u_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .byte_valid_i         (byte_ch.valid),
    .byte_ready_i         (byte_ch.ready),
    .data_byte_i          (byte_ch.data_byte),
    .frame_start_i        (byte_ch.frame_start),
    .res_valid_i          (res_ch.valid),
    .res_ready_i          (res_ch.ready),
    .temperature_tenths_i (res_ch.temperature_tenths),
    .present_i            (res_ch.present),
    .changed_i            (res_ch.changed),
    .crc_ok_i             (res_ch.crc_ok),
    .bridge_reinit_i      (res_ch.bridge_reinit),
    .cfg_valid_i          (cfg_ch.valid),
    .cfg_ready_i          (cfg_ch.ready),
    .cfg_index_i          (cfg_ch.index),
    .cfg_data_i           (cfg_ch.data),
    .pending_o            (pending),
    .mismatches_o         (mismatches),
    .results_o            (results),
    .good_crc_o           (good_crc)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic push_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < gap_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.frame_start <= fs;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_t f, input int count, input logic with_start);
    for (int i = 0; i < count; i++) begin
      push_byte(f[i], with_start && i == 0);
    end
  endtask

  function automatic frame_t make_frame(input logic [15:0] raw, input logic [7:0] res_code,
                                        input logic [7:0] remain, input logic [7:0] per_deg);
    frame_t f;
    f[POS_TEMP_LSB] = raw[7:0];
    f[POS_TEMP_MSB] = raw[15:8];
    f[2]            = 8'($urandom);
    f[3]            = 8'($urandom);
    f[POS_CONFIG]   = res_code;
    f[5]            = 8'($urandom);
    f[POS_REMAIN]   = remain;
    f[POS_PER_DEG]  = per_deg;
    f[FRAME_BYTES - 1] = frame_crc(f);
    return f;
  endfunction

  // Weighted toward the absent and power-on readings, repeats and the range ends.
  function automatic frame_t random_frame();
    logic [15:0] raw;
    logic [7:0]  res_code;
    logic [7:0]  remain;
    logic [7:0]  per_deg;
    case ($urandom_range(11))
      0:       raw = 16'h0550;
      1:       raw = 16'hF810;
      2:       raw = 16'h00AA;
      3:       raw = 16'hFF02;
      4, 5:    raw = last_raw;
      6:       raw = 16'($urandom_range(64)) - 16'd32;
      7: begin
        case ($urandom_range(3))
          0:       raw = 16'h7FFF;
          1:       raw = 16'h8000;
          2:       raw = 16'h0000;
          default: raw = 16'hFFFF;
        endcase
      end
      default: raw = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0:       res_code = RES_12BIT;
      1:       res_code = RES_11BIT;
      2:       res_code = RES_10BIT;
      3:       res_code = RES_9BIT;
      4, 5:    res_code = RES_12BIT;
      default: res_code = ($urandom_range(1) == 0) ? 8'($urandom) : RES_9BIT;
    endcase
    case ($urandom_range(5))
      0:       per_deg = 8'h00;
      1, 2:    per_deg = 8'd16;
      default: per_deg = 8'($urandom);
    endcase
    remain   = ($urandom_range(1) == 0) ? 8'($urandom_range(16)) : 8'($urandom);
    if (raw == 16'h00AA || raw == 16'hFF02) begin
      if ($urandom_range(1) == 0) begin
        remain  = 8'd12;
        per_deg = 8'd16;
      end
    end
    last_raw = raw;
    return make_frame(raw, res_code, remain, per_deg);
  endfunction

  // Registers change only once every result is out and the divider has had time to finish.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] fam, input logic rnd);
    drain();
    write_reg(REG_FAMILY, fam);
    write_reg(REG_ROUND, {7'($urandom), rnd});
    // Writes to unmapped indexes must leave both registers alone.
    if ($urandom_range(1) == 0) write_reg(8'($urandom_range(2, 255)), 8'($urandom));
    settings_used++;
  endtask

  task automatic set_idling(input int sender, input int receiver);
    gap_pct   = sender;
    stall_pct <= receiver;
  endtask

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    frame_t      f;
    int          random_start;
    int          next_switch;
    int          progress;
    int          pick;
    logic [7:0]  fam;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = 8'h00;
    byte_ch.frame_start = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = 8'h00;
    cfg_ch.data         = 8'h00;
    res_ch.ready        = 1'b0;
    gap_pct             = 19;
    stall_pct           = 77;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings: high-resolution family, truncation.
    // Right after reset the first byte counts as byte 0 even without a start marker.
    send_frame(make_frame(16'h0191, RES_12BIT, 8'h0C, 8'h10), FRAME_BYTES, 1'b0);
    send_frame(zero_frame, FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h7FFF, RES_12BIT, 8'h00, 8'h00), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h8000, RES_12BIT, 8'hFF, 8'hFF), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h0550, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'hF810, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'hFFFF, RES_11BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'hFFFF, RES_10BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'hFFFF, RES_9BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h0123, 8'h00, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    f = make_frame(16'h0123, RES_12BIT, 8'h00, 8'h10);
    f[FRAME_BYTES - 1] ^= 8'h5A;
    send_frame(f, FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h0100, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    // A start marker in mid frame restarts it; bytes after the ninth are dropped.
    send_frame(make_frame(16'h0321, RES_12BIT, 8'h00, 8'h10), 4, 1'b1);
    send_frame(make_frame(16'h0322, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);

    apply_setting(FAM_HIGH_A, 1'b1);
    send_frame(make_frame(16'h0004, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h000C, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h0008, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'hFFFC, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h0123, 8'hFF, 8'h00, 8'h10), FRAME_BYTES, 1'b1);

    apply_setting(FAM_LOW, 1'b0);
    send_frame(make_frame(16'h0033, RES_12BIT, 8'h05, 8'h00), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h00AA, RES_12BIT, 8'd12, 8'd16), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h7FFF, RES_12BIT, 8'hFF, 8'h01), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h8000, RES_12BIT, 8'h00, 8'hFF), FRAME_BYTES, 1'b1);

    apply_setting(FAM_LOW, 1'b1);
    send_frame(make_frame(16'hFF02, RES_12BIT, 8'd12, 8'd16), FRAME_BYTES, 1'b1);
    send_frame(make_frame(16'h0033, RES_12BIT, 8'd7, 8'd16), FRAME_BYTES, 1'b1);

    apply_setting(8'hFF, 1'b1);
    send_frame(make_frame(16'h0200, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    apply_setting(8'h00, 1'b0);
    send_frame(make_frame(16'h0200, RES_12BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);
    apply_setting(FAM_HIGH_B, 1'b0);
    send_frame(make_frame(16'h0191, RES_10BIT, 8'h00, 8'h10), FRAME_BYTES, 1'b1);

    // Random part: mostly whole frames, some cut short, unmarked, all zero or loose bytes.
    random_start = bytes_sent;
    next_switch  = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      progress = bytes_sent - random_start;
      if (bytes_sent >= next_switch) begin
        case ($urandom_range(9))
          0, 1, 2: fam = FAM_HIGH_A;
          3:       fam = FAM_HIGH_B;
          4, 5, 6: fam = FAM_LOW;
          7:       fam = 8'h00;
          8:       fam = 8'hFF;
          default: fam = 8'($urandom);
        endcase
        apply_setting(fam, 1'($urandom_range(1)));
        next_switch = bytes_sent + SETTING_SPAN;
      end
      if (progress < RANDOM_BYTES / 3) begin
        set_idling(19, 77);
      end else if (progress < 2 * RANDOM_BYTES / 3) begin
        set_idling(77, 19);
      end else begin
        set_idling(0, 0);
      end
      pick = $urandom_range(99);
      if (pick < 78) begin
        f = random_frame();
        if ($urandom_range(9) == 0) f[$urandom_range(FRAME_BYTES - 1)] ^= 8'(1 << $urandom_range(7));
        send_frame(f, FRAME_BYTES, 1'b1);
      end else if (pick < 84) begin
        send_frame(random_frame(), $urandom_range(1, FRAME_BYTES - 1), 1'b1);
      end else if (pick < 90) begin
        send_frame(random_frame(), FRAME_BYTES, 1'b0);
      end else if (pick < 94) begin
        send_frame(zero_frame, FRAME_BYTES, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'($urandom_range(1)));
      end
    end

    drain();
    $display("Sent %0d scratchpad bytes under %0d register settings.", bytes_sent,
             settings_used);
    $display("Checked %0d result beats, %0d of them with a good CRC.", results, good_crc);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ows_pkg.sv
rtl/core/ows_if.sv
rtl/core/ows_front.sv
rtl/core/ows_queue.sv
rtl/core/ows_back.sv
rtl/core/onewire_temp_scratchpad_decoder.sv
verif/scratchpad_tb_pkg.sv
verif/scratchpad_result_checker.sv
verif/onewire_temp_scratchpad_decoder_test.sv
